[sv/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
// Item field widths, operation and status codes, controller states.
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_REAR  = 3'd0,
    K_PUSH_FRONT = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_REAR   = 3'd3,
    K_LIST       = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DATA
  } fsm_t;

  typedef struct packed {
    logic we;
    logic re;
  } dq_mem_ctl_t;

endpackage

[sv/dq_in_if.sv]
// Input item channel: valid/ready handshake with operation and push word.
// Depends on dq_pkg.
`timescale 1ns / 1ps

interface dq_in_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

[sv/dq_out_if.sv]
// Result item channel: valid/ready handshake with word, status and last flag.
// Depends on dq_pkg.
`timescale 1ns / 1ps

interface dq_out_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] out_value;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, output out_value, output status, output last,
                  input ready);
  modport sink   (input valid, input out_value, input status, input last,
                  output ready);
endinterface

[sv/dq_ram.sv]
// Entry store: one write port, one read port, registered read data.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_ram #(
  parameter int DEPTH  = dq_pkg::DEPTH_DEF,
  parameter int DATA_W = dq_pkg::DATA_W_DEF
) (
  input  logic                       clk,
  input  dq_pkg::dq_mem_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]          rdata
);
  import dq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/dq_ctrl.sv]
// Queue controller: head and count registers, operation sequencing,
// listing walk and the result register. Depends on dq_pkg and the channels.
`timescale 1ns / 1ps

module dq_ctrl #(
  parameter int DEPTH  = dq_pkg::DEPTH_DEF,
  parameter int DATA_W = dq_pkg::DATA_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dq_in_if.sink                      in_if,
  dq_out_if.source                   out_if,
  output dq_pkg::dq_mem_ctl_t        mem_ctl,
  output logic [$clog2(DEPTH)-1:0]   waddr,
  output logic [DATA_W-1:0]          wdata,
  output logic [$clog2(DEPTH)-1:0]   raddr,
  input  logic [DATA_W-1:0]          rdata
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  fsm_t              state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pop_r, pop_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_value_r, out_value_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic                     last_r, last_nxt;

  logic              out_free;
  logic              accept;
  logic [AW-1:0]     head_inc, head_dec, addr_inc;
  logic [AW-1:0]     pos_cnt, pos_cnt_m1;
  logic [SW-1:0]     sum_cnt, sum_cnt_m1;
  logic signed [63:0] push_ext;
  logic signed [DATA_W-1:0] rd_s;
  logic signed [63:0] rd_ext;
  logic              walk_last;

  always_comb begin
    head_inc   = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    head_dec   = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
    addr_inc   = (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + AW'(1);
    sum_cnt    = SW'(head_r) + SW'(count_r);
    sum_cnt_m1 = sum_cnt - SW'(1);
    pos_cnt    = (sum_cnt >= SW'(DEPTH)) ? AW'(sum_cnt - SW'(DEPTH)) : AW'(sum_cnt);
    pos_cnt_m1 = (sum_cnt_m1 >= SW'(DEPTH)) ? AW'(sum_cnt_m1 - SW'(DEPTH))
                                             : AW'(sum_cnt_m1);
    push_ext   = 64'(in_if.push_value);
    rd_s       = rdata;
    rd_ext     = 64'(rd_s);
    walk_last  = pop_r || (idx_r == count_r);
  end

  assign out_free = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && out_free;
  assign accept = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    idx_r       <= idx_nxt;
    pop_r       <= pop_nxt;
    out_value_r <= out_value_nxt;
    status_r    <= status_nxt;
    last_r      <= last_nxt;
  end

  // Writes happen only at a push accept; reads only at a pop or list accept
  // or in the walk, so the store never sees a read and a write in one cycle.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    idx_nxt       = idx_r;
    pop_nxt       = pop_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_value_nxt = out_value_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    mem_ctl       = '0;
    waddr         = pos_cnt;
    wdata         = push_ext[DATA_W-1:0];
    raddr         = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_if.kind)
            K_PUSH_REAR, K_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              last_nxt      = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt = ST_OK;
                mem_ctl.we = 1'b1;
                count_nxt  = count_r + CW'(1);
                if (in_if.kind == K_PUSH_FRONT) begin
                  waddr    = head_dec;
                  head_nxt = head_dec;
                end
              end
            end
            K_POP_FRONT, K_POP_REAR: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_value_nxt = '0;
                status_nxt    = ST_EMPTY;
                last_nxt      = 1'b1;
              end else begin
                mem_ctl.re = 1'b1;
                count_nxt  = count_r - CW'(1);
                pop_nxt    = 1'b1;
                state_nxt  = S_DATA;
                if (in_if.kind == K_POP_FRONT) begin
                  head_nxt = head_inc;
                end else begin
                  raddr = pos_cnt_m1;
                end
              end
            end
            K_LIST: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_value_nxt = '0;
                status_nxt    = ST_EMPTY;
                last_nxt      = 1'b1;
              end else begin
                mem_ctl.re = 1'b1;
                addr_nxt   = head_inc;
                idx_nxt    = CW'(1);
                pop_nxt    = 1'b0;
                state_nxt  = S_DATA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_ext[WORD_W-1:0];
          status_nxt    = ST_OK;
          last_nxt      = walk_last;
          if (walk_last) begin
            state_nxt = S_IDLE;
          end else begin
            mem_ctl.re = 1'b1;
            raddr      = addr_r;
            addr_nxt   = addr_inc;
            idx_nxt    = idx_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_value = out_value_r;
  assign out_if.status    = status_r;
  assign out_if.last      = last_r;

endmodule

[sv/double_ended_queue.sv]
// Bounded double-ended queue of signed words in a ring store.
// Channels: in_if carries kind and push_value, out_if carries out_value,
// status and last; both move an item when valid and ready are high.
// Push rear/front: one result (ok or full) registered at the accept edge,
// visible the next cycle. Pop front/rear: the store read data is registered,
// then loaded into the result register once it is free. Empty-queue pop or
// list gives one result with status empty.
// List: one result per held entry, front to rear, last set on the rear
// entry; the first result passes the store read and result registers, then
// one per cycle while out_if.ready stays high, paced by the store read port.
// Throughput: one push per cycle while out_if.ready stays high; pops and
// lists take one item at a time, until the pop or last entry result loads.
// Kinds 5 to 7 are taken and produce nothing.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; the store contents are not cleared.
// With a result pending and out_if.ready low, the result register holds,
// in_if.ready drops and a listing pauses in place until the result is taken.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH  = dq_pkg::DEPTH_DEF,
  parameter int DATA_W = dq_pkg::DATA_W_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_if,
  dq_out_if.source out_if
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  dq_mem_ctl_t       mem_ctl;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;

  dq_ctrl #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  dq_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.we |-> (in_if.valid && in_if.ready))
    else $error("store write without an accepted item");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.we && mem_ctl.re))
    else $error("store read and write in the same cycle");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != ST_OK) |-> out_if.last)
    else $error("error result not marked last");

  a_walk_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.re && !(in_if.valid && in_if.ready)) |=> out_if.valid)
    else $error("listing read issued without loading a result");

endmodule

[sim/tb.sv]
// Self-checking bench for double_ended_queue: a directed stimulus table, then random
// push/pop/list traffic under several idle and stall mixes, all checked in order.
// Depends on dq_pkg, dq_in_if, dq_out_if and the double_ended_queue RTL.
`timescale 1ns / 1ps

module tb;
  import dq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int RAND_ITEMS = 380;
  localparam int HOLD_LEN   = 80;
  localparam int SCRIPT_LEN = 25;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    status_t                  status;
    logic                     last;
  } deque_result_t;

  typedef struct packed {
    logic [KIND_W-1:0]        op;
    logic signed [WORD_W-1:0] word;
    logic [5:0]               reps;
    logic                     typed;
    logic signed [WORD_W-1:0] want_value;
    status_t                  want_status;
  } step_t;

  typedef enum {FILL_BIAS, DRAIN_BIAS, MIXED_BIAS} bias_t;

  logic clk;
  logic rst_n;

  dq_in_if  in_ch();
  dq_out_if out_ch();

  double_ended_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  // deque mirror
  logic signed [WORD_W-1:0] ring_words [DEPTH];
  int ring_front = 0;
  int ring_held  = 0;

  deque_result_t awaited_results [$];

  int faults       = 0;
  int ops_seen     = 0;
  int lists_seen   = 0;
  int full_seen    = 0;
  int empty_seen   = 0;
  int results_seen = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;

  step_t script [0:SCRIPT_LEN-1] = '{
    '{K_POP_FRONT,  32'sd0,         6'd1,  1'b1, 32'sd0,    ST_EMPTY},
    '{K_POP_REAR,   32'sd0,         6'd1,  1'b1, 32'sd0,    ST_EMPTY},
    '{K_LIST,       32'sd0,         6'd1,  1'b1, 32'sd0,    ST_EMPTY},
    '{KIND_SPARE_A, 32'h5555_5555,  6'd1,  1'b0, 32'sd0,    ST_OK},
    '{K_PUSH_REAR,  WORD_MAX,       6'd1,  1'b1, 32'sd0,    ST_OK},
    '{K_POP_REAR,   32'sd0,         6'd1,  1'b1, WORD_MAX,  ST_OK},
    '{K_PUSH_FRONT, WORD_MIN,       6'd1,  1'b1, 32'sd0,    ST_OK},
    '{K_POP_FRONT,  32'sd0,         6'd1,  1'b1, WORD_MIN,  ST_OK},
    '{K_POP_FRONT,  32'sd0,         6'd1,  1'b1, 32'sd0,    ST_EMPTY},
    '{K_PUSH_FRONT, -32'sd1,        6'd1,  1'b1, 32'sd0,    ST_OK},
    '{K_PUSH_REAR,  32'sd0,         6'd1,  1'b1, 32'sd0,    ST_OK},
    '{K_PUSH_FRONT, 32'sd1,         6'd1,  1'b1, 32'sd0,    ST_OK},
    '{K_LIST,       32'sd0,         6'd1,  1'b0, 32'sd0,    ST_OK},
    '{K_POP_REAR,   32'sd0,         6'd1,  1'b0, 32'sd0,    ST_OK},
    '{KIND_SPARE_B, 32'haaaa_aaaa,  6'd1,  1'b0, 32'sd0,    ST_OK},
    '{K_PUSH_REAR,  32'sd100,       6'd14, 1'b1, 32'sd0,    ST_OK},
    '{K_PUSH_REAR,  WORD_MAX,       6'd1,  1'b1, 32'sd0,    ST_FULL},
    '{K_PUSH_FRONT, WORD_MIN,       6'd1,  1'b1, 32'sd0,    ST_FULL},
    '{K_LIST,       32'sd0,         6'd1,  1'b0, 32'sd0,    ST_OK},
    '{KIND_SPARE_C, -32'sd1,        6'd1,  1'b0, 32'sd0,    ST_OK},
    '{K_POP_FRONT,  32'sd0,         6'd9,  1'b0, 32'sd0,    ST_OK},
    '{K_PUSH_FRONT, -32'sd512,      6'd9,  1'b1, 32'sd0,    ST_OK},
    '{K_POP_REAR,   32'sd0,         6'd16, 1'b0, 32'sd0,    ST_OK},
    '{K_POP_REAR,   32'sd0,         6'd1,  1'b1, 32'sd0,    ST_EMPTY},
    '{K_LIST,       32'sd0,         6'd1,  1'b1, 32'sd0,    ST_EMPTY}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("[double_ended_queue] ERROR");
    $finish;
  end

  function automatic void predict_deque_results(input logic [KIND_W-1:0] op,
                                                input logic signed [WORD_W-1:0] word,
                                                input bit keep);
    deque_result_t r;
    bit single;
    int pos;
    r = '{value: '0, status: ST_OK, last: 1'b1};
    single = 1'b1;
    ops_seen++;
    case (op)
      K_PUSH_REAR, K_PUSH_FRONT: begin
        if (ring_held == DEPTH) begin
          r.status = ST_FULL;
          full_seen++;
        end else begin
          if (op == K_PUSH_REAR) begin
            ring_words[(ring_front + ring_held) % DEPTH] = word;
          end else begin
            ring_front = (ring_front + DEPTH - 1) % DEPTH;
            ring_words[ring_front] = word;
          end
          ring_held++;
        end
      end
      K_POP_FRONT, K_POP_REAR: begin
        if (ring_held == 0) begin
          r.status = ST_EMPTY;
          empty_seen++;
        end else begin
          if (op == K_POP_FRONT) begin
            r.value = ring_words[ring_front];
            ring_front = (ring_front + 1) % DEPTH;
          end else begin
            r.value = ring_words[(ring_front + ring_held - 1) % DEPTH];
          end
          ring_held--;
        end
      end
      K_LIST: begin
        lists_seen++;
        if (ring_held == 0) begin
          r.status = ST_EMPTY;
          empty_seen++;
        end else begin
          single = 1'b0;
          for (pos = 0; pos < ring_held; pos++) begin
            r.value = ring_words[(ring_front + pos) % DEPTH];
            r.last  = (pos == ring_held - 1);
            if (keep) awaited_results.push_back(r);
          end
        end
      end
      default: begin
        single = 1'b0;
        ops_seen--;
      end
    endcase
    if (keep && single) awaited_results.push_back(r);
  endfunction

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%0t: %s", $time, msg);
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] op, input logic signed [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= op;
    in_ch.push_value <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // sender pause: hold off until every awaited result has come back
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (awaited_results.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", awaited_results.size()));
      awaited_results.delete();
    end
    @(posedge clk);
  endtask

  // receiver: random stalls plus a single long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        note_fault($sformatf("unexpected result value %0d status %0d last %0b",
                             out_ch.out_value, out_ch.status, out_ch.last));
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.out_value !== want.value || out_ch.status !== want.status ||
            out_ch.last !== want.last)
          note_fault($sformatf("mismatch: value exp %0d got %0d, status exp %0d got %0d, last exp %0b got %0b",
                               want.value, out_ch.out_value, want.status, out_ch.status,
                               want.last, out_ch.last));
      end
    end
  end

  initial begin
    logic [KIND_W-1:0]        op;
    logic signed [WORD_W-1:0] word;
    bias_t                    bias;
    int                       bias_left;
    int                       counted;
    int                       target;
    int                       push_pct;
    bit                       hold_done;

    bias      = MIXED_BIAS;
    bias_left = 0;
    counted   = 0;
    hold_done = 1'b0;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = K_PUSH_REAR;
    in_ch.push_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < SCRIPT_LEN; n++) begin
      for (int k = 0; k < script[n].reps; k++) begin
        send_item(script[n].op, script[n].word + k);
        predict_deque_results(script[n].op, script[n].word + k, !script[n].typed);
        if (script[n].typed)
          awaited_results.push_back('{value: script[n].want_value,
                                      status: script[n].want_status, last: 1'b1});
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      target = RAND_ITEMS * (phase + 1) / 4;
      while (counted < target) begin
        if (bias_left == 0) begin
          bias      = bias_t'($urandom_range(2));
          bias_left = $urandom_range(10, 40);
        end
        bias_left--;
        case (bias)
          FILL_BIAS:  push_pct = 75;
          DRAIN_BIAS: push_pct = 25;
          default:    push_pct = 50;
        endcase
        case ($urandom_range(7))
          0: word = WORD_MIN;
          1: word = WORD_MAX;
          2: word = '0;
          3: word = -1;
          default: word = $urandom;
        endcase
        if ($urandom_range(99) < 3) begin
          case ($urandom_range(2))
            0: op = KIND_SPARE_A;
            1: op = KIND_SPARE_B;
            default: op = KIND_SPARE_C;
          endcase
        end else begin
          counted++;
          if ($urandom_range(99) < 8)
            op = K_LIST;
          else if ($urandom_range(99) < push_pct)
            op = $urandom_range(1) ? K_PUSH_FRONT : K_PUSH_REAR;
          else
            op = $urandom_range(1) ? K_POP_FRONT : K_POP_REAR;
        end
        send_item(op, word);
        predict_deque_results(op, word, 1'b1);
        if (phase == 0 && counted >= 40 && !hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end
    end

    wait_drained();
    $display("covered %0d operations (%0d listings), %0d results checked", ops_seen,
             lists_seen, results_seen);
    $display("full queue hit %0d times, empty queue hit %0d times", full_seen, empty_seen);
    if (faults == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("%0d failures", faults);
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/dq_pkg.sv
sv/dq_in_if.sv
sv/dq_out_if.sv
sv/dq_ram.sv
sv/dq_ctrl.sv
sv/double_ended_queue.sv
sim/tb.sv
